// ===== rtl/lms_pkg.sv =====
// Shared widths, constants and control types of the LMS adaptive FIR.
`default_nettype none
package lms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 16;
    localparam int ME_W     = STEP_W + SAMPLE_W + 1;
    localparam int PROD_W   = ME_W + SAMPLE_W;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

    typedef struct packed {
        logic issue;
        logic update;
        logic acc_clr;
        logic finalize;
        logic load_me;
    } t_dp_ctrl;

    typedef struct packed {
        logic busy;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/lms_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/lms_datapath.sv =====
// Shared multiply-accumulate, rounding, saturation and weight update datapath.
`default_nettype none
module lms_datapath #(
    parameter int TAPS = 32,
    localparam int AW = $clog2(TAPS)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire lms_pkg::t_dp_ctrl                     i_ctrl,
    input  wire logic [AW-1:0]                         i_idx,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0]   i_tap,
    input  wire logic signed [lms_pkg::WEIGHT_W-1:0]   i_wt,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0]   i_desired,
    input  wire logic [lms_pkg::STEP_W-1:0]            i_step,
    output lms_pkg::t_dp_stat                          o_stat,
    output logic                                       o_wr_en,
    output logic [AW-1:0]                              o_wr_addr,
    output logic signed [lms_pkg::WEIGHT_W-1:0]        o_wr_data,
    output logic signed [lms_pkg::SAMPLE_W-1:0]        o_est,
    output logic signed [lms_pkg::SAMPLE_W-1:0]        o_err
);

    localparam int SW    = lms_pkg::SAMPLE_W;
    localparam int WW    = lms_pkg::WEIGHT_W;
    localparam int MW    = lms_pkg::ME_W;
    localparam int PW    = lms_pkg::PROD_W;
    localparam int ACC_W = PW + AW;
    localparam int RND_W = ACC_W - 28;
    localparam int DW    = PW - 18;

    localparam logic signed [RND_W-1:0] EST_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] EST_MIN = RND_W'(-32768);
    localparam logic signed [SW:0]      ERR_MAX = (SW+1)'(32767);
    localparam logic signed [SW:0]      ERR_MIN = (SW+1)'(-32768);
    localparam logic signed [WW:0]      W_MAX   = (WW+1)'(64'sh7FFF_FFFF);
    localparam logic signed [WW:0]      W_MIN   = (WW+1)'(-64'sh8000_0000);

    logic                    r_v1, r_u1, r_v2, r_u2;
    logic [AW-1:0]           r_i1, r_i2;
    logic signed [PW-1:0]    r_prod;
    logic signed [WW-1:0]    r_wt2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SW-1:0]    r_est, r_err;
    logic signed [MW-1:0]    r_me;

    logic signed [MW-1:0]    mul_a;
    logic signed [PW-1:0]    mul_p;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [RND_W-1:0] est_v;
    logic signed [SW-1:0]    n_est;
    logic signed [SW:0]      err_v;
    logic signed [SW-1:0]    n_err;
    logic signed [MW-1:0]    n_me;
    logic signed [PW-1:0]    d_full;
    logic signed [DW-1:0]    d_v;
    logic signed [WW:0]      w_sum;

    always_comb begin
        mul_a = r_u1 ? r_me : MW'(i_wt);
        mul_p = mul_a * i_tap;

        acc_rnd = r_acc + ACC_W'(2**27);
        est_v   = $signed(acc_rnd[ACC_W-1:28]);
        if (est_v > EST_MAX) begin
            n_est = SW'(EST_MAX);
        end else if (est_v < EST_MIN) begin
            n_est = SW'(EST_MIN);
        end else begin
            n_est = SW'(est_v);
        end

        err_v = (SW+1)'(i_desired) - (SW+1)'(r_est);
        if (err_v > ERR_MAX) begin
            n_err = SW'(ERR_MAX);
        end else if (err_v < ERR_MIN) begin
            n_err = SW'(ERR_MIN);
        end else begin
            n_err = SW'(err_v);
        end

        n_me = $signed({1'b0, i_step}) * r_err;

        d_full = r_prod + PW'(2**17);
        d_v    = $signed(d_full[PW-1:18]);
        w_sum  = (WW+1)'(r_wt2) + (WW+1)'(d_v);
        if (w_sum > W_MAX) begin
            o_wr_data = WW'(W_MAX);
        end else if (w_sum < W_MIN) begin
            o_wr_data = WW'(W_MIN);
        end else begin
            o_wr_data = WW'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;
        end
        r_u1   <= i_ctrl.update;
        r_i1   <= i_idx;
        r_u2   <= r_u1;
        r_i2   <= r_i1;
        r_prod <= mul_p;
        r_wt2  <= i_wt;

        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2 && !r_u2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end

        // estimate first, error from the saturated estimate in the following cycle
        if (i_ctrl.finalize) begin
            r_est <= n_est;
        end
        if (i_ctrl.load_me) begin
            r_err <= n_err;
        end
        r_me <= n_me;
    end

    assign o_stat.busy = r_v1 | r_v2;
    assign o_wr_en     = r_v2 & r_u2;
    assign o_wr_addr   = r_i2;
    assign o_est       = r_est;
    assign o_err       = n_err;

endmodule
`default_nettype wire

// ===== rtl/lms_adaptive_fir.sv =====
// Top level of the LMS adaptive FIR: sequencer, tap and weight memories.
//
// Input requests carry noisy_sample, desired_sample and train on a
// valid/ready channel; one result (estimate, error) leaves per request on
// a second valid/ready channel through an output register.
// step_size is written on its own valid/ready channel, always ready; write
// it only while the filter is idle.
// When train is set the shared multiplier walks the taps once for the
// estimate and once for the update; when train is clear it walks them
// only for the estimate. The result is ready after the estimate pass,
// before the weight update runs.
// After reset a clearing pass zeroes both memories; no request is
// accepted during it. step_size resets to 328.
// A stalled receiver holds the result; the next request can be accepted,
// and its sequencer waits once its own result is ready until the output
// register is free.
`default_nettype none
module lms_adaptive_fir #(
    parameter int TAPS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0] i_noisy_sample,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0] i_desired_sample,
    input  wire logic                                i_train,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [lms_pkg::SAMPLE_W-1:0]      o_estimate,
    output logic signed [lms_pkg::SAMPLE_W-1:0]      o_error,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lms_pkg::STEP_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(TAPS);
    localparam int SW = lms_pkg::SAMPLE_W;
    localparam int WW = lms_pkg::WEIGHT_W;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EST   = 7'b0000100,
        S_FIN   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_WB    = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_taddr, n_taddr;
    logic [AW-1:0]           r_wp, n_wp;
    logic [lms_pkg::STEP_W-1:0] r_step;
    logic signed [SW-1:0]    r_desired;
    logic                    r_train;
    logic                    r_out_valid, n_out_valid;
    logic signed [SW-1:0]    r_o_est, r_o_err;
    logic                    r_fin_phase;

    logic                    in_acc, out_load;
    logic [AW-1:0]           wp_inc, taddr_dec;
    lms_pkg::t_dp_ctrl       dp_ctrl;
    lms_pkg::t_dp_stat       dp_stat;

    logic                    tap_we;
    logic [AW-1:0]           tap_waddr;
    logic signed [SW-1:0]    tap_wdata;
    logic [SW-1:0]           tap_rdata;
    logic                    wt_we;
    logic [AW-1:0]           wt_waddr;
    logic signed [WW-1:0]    wt_wdata;
    logic [WW-1:0]           wt_rdata;

    logic                    dp_we;
    logic [AW-1:0]           dp_waddr;
    logic signed [WW-1:0]    dp_wdata;
    logic signed [SW-1:0]    dp_est, dp_err;

    assign wp_inc    = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign taddr_dec = (r_taddr == '0) ? LAST : r_taddr - 1'b1;
    assign in_acc    = i_in_valid & o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_taddr     = r_taddr;
        n_wp        = r_wp;
        n_out_valid = r_out_valid & ~i_out_ready;
        out_load    = 1'b0;
        dp_ctrl     = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_wp            = wp_inc;
                    n_taddr         = wp_inc;
                    n_idx           = '0;
                    dp_ctrl.acc_clr = 1'b1;
                    n_state         = S_EST;
                end
            end
            S_EST: begin
                dp_ctrl.issue = 1'b1;
                n_idx         = r_idx + 1'b1;
                n_taddr       = taddr_dec;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_taddr = r_wp;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // latch estimate, then error
                if (!dp_stat.busy) begin
                    dp_ctrl.finalize = ~r_fin_phase;
                    if (r_fin_phase) begin
                        dp_ctrl.load_me = 1'b1;
                        n_state         = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = r_train ? S_UPD : S_IDLE;
                end
            end
            S_UPD: begin
                dp_ctrl.issue  = 1'b1;
                dp_ctrl.update = 1'b1;
                n_idx          = r_idx + 1'b1;
                n_taddr        = taddr_dec;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!dp_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_taddr     <= '0;
            r_wp        <= '0;
            r_step      <= lms_pkg::STEP_RESET;
            r_out_valid <= 1'b0;
            r_fin_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_taddr     <= n_taddr;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
            r_fin_phase <= (r_state == S_FIN) && !dp_stat.busy && !r_fin_phase;
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
        end
        if (in_acc) begin
            r_desired <= i_desired_sample;
            r_train   <= i_train;
        end
        if (out_load) begin
            r_o_est <= dp_est;
            r_o_err <= dp_err;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            tap_we    = 1'b1;
            tap_waddr = r_idx;
            tap_wdata = '0;
            wt_we     = 1'b1;
            wt_waddr  = r_idx;
            wt_wdata  = '0;
        end else begin
            tap_we    = in_acc;
            tap_waddr = wp_inc;
            tap_wdata = i_noisy_sample;
            wt_we     = dp_we;
            wt_waddr  = dp_waddr;
            wt_wdata  = dp_wdata;
        end
    end

    lms_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_raddr (r_taddr),
        .o_rdata (tap_rdata)
    );

    lms_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_idx),
        .o_rdata (wt_rdata)
    );

    lms_datapath #(.TAPS(TAPS)) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (dp_ctrl),
        .i_idx     (r_idx),
        .i_tap     ($signed(tap_rdata)),
        .i_wt      ($signed(wt_rdata)),
        .i_desired (r_desired),
        .i_step    (r_step),
        .o_stat    (dp_stat),
        .o_wr_en   (dp_we),
        .o_wr_addr (dp_waddr),
        .o_wr_data (dp_wdata),
        .o_est     (dp_est),
        .o_err     (dp_err)
    );

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_o_est;
    assign o_error     = r_o_err;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== sim/tb_lms_adaptive_fir.sv =====
// Testbench for lms_adaptive_fir: directed and random requests checked against a bit-exact model.
`default_nettype none
module tb_lms_adaptive_fir;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W                = lms_pkg::SAMPLE_W;
    localparam int WEIGHT_W                = lms_pkg::WEIGHT_W;
    localparam int STEP_W                  = lms_pkg::STEP_W;
    localparam logic [STEP_W-1:0] STEP_RESET = lms_pkg::STEP_RESET;

    localparam int TAPS             = 32;
    localparam int SETTLE_CYCLES    = 2 * TAPS + 30;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 330;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam longint W_MAX = longint'(2147483647);
    localparam longint W_MIN = -longint'(2147483647) - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] estimate;
        logic signed [SAMPLE_W-1:0] error;
    } t_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_noisy_sample;
    logic signed [SAMPLE_W-1:0] i_desired_sample;
    logic                       i_train;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SAMPLE_W-1:0] o_estimate;
    logic signed [SAMPLE_W-1:0] o_error;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [STEP_W-1:0]          i_cfg_data;

    // filter model state
    logic signed [SAMPLE_W-1:0] model_taps [TAPS];
    logic signed [WEIGHT_W-1:0] model_weights [TAPS];
    logic [STEP_W-1:0]          model_mu;

    t_result expected_results[$];
    int      sender_idle_pct   = 32;
    int      receiver_idle_pct = 67;
    int      stall_left        = 0;
    int      fail_count        = 0;
    int      requests_sent     = 0;
    int      results_checked   = 0;
    int      trained_requests  = 0;
    int      step_writes       = 0;
    int      cycle_count       = 0;

    lms_adaptive_fir #(
        .TAPS(TAPS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_noisy_sample  (i_noisy_sample),
        .i_desired_sample(i_desired_sample),
        .i_train         (i_train),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_estimate      (o_estimate),
        .o_error         (o_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // shift, filter, then optionally adapt; returns the saturated estimate and error
    function automatic t_result lms_filter_step(logic signed [SAMPLE_W-1:0] noisy,
                                                logic signed [SAMPLE_W-1:0] desired,
                                                logic train);
        t_result r;
        longint  acc;
        longint  est;
        longint  err;
        longint  mu_err;
        longint  delta;
        longint  w;
        longint  tap;
        int      i;
        acc = 0;
        for (i = TAPS - 1; i > 0; i--) begin
            model_taps[i] = model_taps[i-1];
        end
        model_taps[0] = noisy;
        for (i = 0; i < TAPS; i++) begin
            w   = model_weights[i];
            tap = model_taps[i];
            acc = acc + w * tap;
        end
        est = (acc + (longint'(1) << 27)) >>> 28;
        if (est > 32767) est = 32767;
        else if (est < -32768) est = -32768;
        err = desired;
        err = err - est;
        if (err > 32767) err = 32767;
        else if (err < -32768) err = -32768;
        if (train) begin
            mu_err = model_mu;
            mu_err = mu_err * err;
            for (i = 0; i < TAPS; i++) begin
                w     = model_weights[i];
                tap   = model_taps[i];
                delta = (mu_err * tap + (longint'(1) << 17)) >>> 18;
                w     = w + delta;
                if (w > W_MAX) w = W_MAX;
                else if (w < W_MIN) w = W_MIN;
                model_weights[i] = 32'(w);
            end
        end
        r.estimate = 16'(est);
        r.error    = 16'(err);
        return r;
    endfunction

    // receiver: random stalls, occasionally long ones
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(99) < receiver_idle_pct) begin
            i_out_ready <= 1'b0;
            if ($urandom_range(15) == 0) stall_left <= $urandom_range(2 * TAPS + 10);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: estimate %0d error %0d", o_estimate, o_error);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                results_checked++;
                if (o_estimate !== exp_r.estimate) begin
                    $error("estimate mismatch: expected %0d, got %0d", exp_r.estimate, o_estimate);
                    fail_count++;
                end
                if (o_error !== exp_r.error) begin
                    $error("error mismatch: expected %0d, got %0d", exp_r.error, o_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("lms_adaptive_fir test failed");
            $finish;
        end
    end

    task automatic send_request(input logic signed [SAMPLE_W-1:0] noisy,
                                input logic signed [SAMPLE_W-1:0] desired,
                                input logic train);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2 * TAPS + 10)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_noisy_sample   <= noisy;
        i_desired_sample <= desired;
        i_train          <= train;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(lms_filter_step(noisy, desired, train));
        requests_sent++;
        if (train) trained_requests++;
    endtask

    // stop requests, let every result drain and the update pass finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_mu = value;
        step_writes++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(11))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return -16'sd1;
            4:       return 16'($signed(16'($urandom_range(255))) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    // default step after reset, extreme samples, a filter-only request
    task automatic test_reset_step();
        send_request(S_MAX, S_MIN, 1'b1);
        send_request(S_MIN, S_MAX, 1'b1);
        send_request('0, '0, 1'b0);
        send_request(-16'sd1, 16'sd1, 1'b1);
        wait_idle();
    endtask

    // largest step drives weights, estimate and error into saturation; step 0 freezes
    task automatic test_saturation();
        write_step('1);
        repeat (10) send_request(S_MAX, S_MIN, 1'b1);
        repeat (4) send_request(S_MAX, S_MAX, 1'b1);
        send_request(S_MIN, '0, 1'b0);
        send_request(S_MIN, S_MAX, 1'b0);
        wait_idle();
        write_step('0);
        repeat (3) send_request(pick_sample(), pick_sample(), 1'b1);
        wait_idle();
    endtask

    // mostly system identification against a fixed plant, some noise requests
    task automatic test_random_phase(input int in_pct, input int out_pct,
                                     input logic [STEP_W-1:0] first_step,
                                     input logic [STEP_W-1:0] second_step);
        logic signed [SAMPLE_W-1:0] hist [3];
        logic signed [SAMPLE_W-1:0] noisy;
        logic signed [SAMPLE_W-1:0] desired;
        logic                       plant_mode;
        logic                       train;
        int                         n;
        sender_idle_pct   = in_pct;
        receiver_idle_pct = out_pct;
        plant_mode        = 1'b1;
        hist              = '{default: '0};
        wait_idle();
        write_step(first_step);
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2) begin
                wait_idle();
                write_step(second_step);
            end
            if (n % 32 == 0) plant_mode = ($urandom_range(9) < 7);
            noisy   = pick_sample();
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = noisy;
            if (plant_mode) begin
                desired = (hist[0] >>> 1) - (hist[2] >>> 2);
                train   = ($urandom_range(19) != 0);
            end else begin
                desired = pick_sample();
                train   = 1'($urandom);
            end
            send_request(noisy, desired, train);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_noisy_sample   <= '0;
        i_desired_sample <= '0;
        i_train          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= '0;
        model_taps        = '{default: '0};
        model_weights     = '{default: '0};
        model_mu          = STEP_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_step();
        test_saturation();
        test_random_phase(32, 67, STEP_RESET, '0);
        test_random_phase(67, 32, 16'($urandom_range(1, 4096)), '1);
        test_random_phase(0, 0, 16'($urandom_range(1, 1024)), 16'($urandom));

        $display("%0d requests (%0d training), %0d results checked, %0d step_size writes",
                 requests_sent, trained_requests, results_checked, step_writes);
        $display("covered saturation, frozen weights, idle sender and stalled receiver mixes");
        if (fail_count == 0) begin
            $display("lms_adaptive_fir test passed");
        end else begin
            $display("lms_adaptive_fir test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lms_pkg.sv
rtl/lms_ram.sv
rtl/lms_datapath.sv
rtl/lms_adaptive_fir.sv
sim/tb_lms_adaptive_fir.sv
